[sv/velocity_command_scale_and_lag_core_macros.svh]
// ----------------------------------------------------------------------------
// Velocity command scale and lag - assertion macros
// Shared concurrent assertion forms for the checker of the core.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_COMMAND_SCALE_AND_LAG_CORE_MACROS_SVH
`define VELOCITY_COMMAND_SCALE_AND_LAG_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define VCSL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define VCSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/vcsl_pkg.sv]
// ----------------------------------------------------------------------------
// Velocity command scale and lag - package
// Field widths, register indexes and transaction kind codes.
// ----------------------------------------------------------------------------
package vcsl_pkg;

    localparam int unsigned VEL_W       = 16;
    localparam int unsigned GAIN_W      = 16;
    localparam int unsigned LAG_W       = 21;
    localparam int unsigned DT_W        = 20;
    localparam int unsigned APP_W       = 24;
    localparam int unsigned APP_FRAC    = 8;
    localparam int unsigned SCALE_SHIFT = 14;

    localparam int unsigned ALPHA_FRAC_BITS_DEF = 16;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 21;

    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LATERAL_GAIN_POS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LATERAL_GAIN_NEG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LATERAL_LAG       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_LAG       = 3'd5;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    localparam logic ACTION_COMMAND = 1'b0;
    localparam logic ACTION_TICK    = 1'b1;

endpackage

[sv/velocity_command_scale_and_lag_core.sv]
// ----------------------------------------------------------------------------
// Velocity command scale and lag - core
// Scales chassis velocity commands and runs a first-order lag per axis.
// ----------------------------------------------------------------------------
// Command transaction: busy for three multiply and write-back pairs, no result.
// Tick transaction: per axis, lag start, F+1 radix-2 alpha divider steps with F =
// ALPHA_FRAC_BITS = 16, multiply and write-back; a zero lag time jumps to the target.
// The result register loads in the last busy cycle and holds until taken downstream.
// Reset is synchronous, active low: gains return to 1.0, lags to zero, targets and
// lag state to zero, and the result register empties.
module velocity_command_scale_and_lag_core #(
    parameter int unsigned ALPHA_FRAC_BITS = vcsl_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [vcsl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [vcsl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, lowest bit up: cmd_forward[15:0], cmd_lateral[31:16],
    // cmd_angular[47:32], elapsed_us[67:48], zero padding[71:68]
    input  logic [vcsl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: action (0 = command, 1 = tick)
    input  logic                                s_axis_tuser,
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata, lowest bit up: out_forward[15:0], out_lateral[31:16], out_angular[47:32]
    output logic [vcsl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // ------------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------------
    localparam int unsigned VW     = vcsl_pkg::VEL_W;
    localparam int unsigned GW     = vcsl_pkg::GAIN_W;
    localparam int unsigned LW     = vcsl_pkg::LAG_W;
    localparam int unsigned DW     = vcsl_pkg::DT_W;
    localparam int unsigned AW     = vcsl_pkg::APP_W;
    localparam int unsigned F      = ALPHA_FRAC_BITS;
    localparam int unsigned QW     = F + 1;            // alpha can reach exactly 1.0
    localparam int unsigned DEN_W  = LW + 1;           // tau + dt
    localparam int unsigned REM_W  = DEN_W + 1;        // partial remainder after shift
    localparam int unsigned NUM_W  = DW + F + 1;       // dt * 2^F + den / 2
    localparam int unsigned OPA_W  = AW + 2;           // signed difference to target
    localparam int unsigned OPB_W  = (QW + 1 > GW + 1) ? QW + 1 : GW + 1;
    localparam int unsigned PROD_W = OPA_W + OPB_W;
    localparam int unsigned CNT_W  = $clog2(F + 1);

    localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(2);
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(F);

    localparam logic signed [PROD_W-1:0] SCALE_HALF = 1 <<< (vcsl_pkg::SCALE_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] LAG_HALF   = 1 <<< (F - 1);
    localparam logic signed [PROD_W-1:0] VEL_MAX_P  = 32767;
    localparam logic signed [PROD_W-1:0] VEL_MIN_P  = -32768;
    localparam logic signed [PROD_W-1:0] APP_MAX_P  = 8388607;
    localparam logic signed [PROD_W-1:0] APP_MIN_P  = -8388608;

    // ------------------------------------------------------------------------
    // Sequencer states
    // ------------------------------------------------------------------------
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCALE_MUL = 4'd1;
    localparam logic [3:0] S_SCALE_WB  = 4'd2;
    localparam logic [3:0] S_LAG_START = 4'd3;
    localparam logic [3:0] S_DIV_INIT  = 4'd4;
    localparam logic [3:0] S_DIV       = 4'd5;
    localparam logic [3:0] S_LAG_MUL   = 4'd6;
    localparam logic [3:0] S_LAG_WB    = 4'd7;
    localparam logic [3:0] S_OUT       = 4'd8;

    // Rounds a lag state (velocity * 256) to whole velocity units, half up,
    // saturating at the top. The bottom cannot overflow.
    function automatic logic signed [VW-1:0] round_out(input logic signed [AW-1:0] a);
        logic signed [AW:0] t;
        t = (AW + 1)'(a) + 25'sd128;
        t = t >>> vcsl_pkg::APP_FRAC;
        if (t > 25'sd32767) begin
            return 16'sh7FFF;
        end
        return t[VW-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    // Configuration
    logic [GW-1:0]              r_gain_fwd;
    logic [GW-1:0]              r_gain_lat_pos;
    logic [GW-1:0]              r_gain_lat_neg;
    logic [GW-1:0]              r_gain_ang;
    logic [LW-1:0]              r_lag_lat;
    logic [LW-1:0]              r_lag_ang;

    // Architectural state
    logic signed [VW-1:0]       r_tgt_fwd;
    logic signed [VW-1:0]       r_tgt_lat;
    logic signed [VW-1:0]       r_tgt_ang;
    logic signed [AW-1:0]       r_app_lat;
    logic signed [AW-1:0]       r_app_ang;

    // Sequencer
    logic [3:0]                 r_state;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_chan;        // 0 = lateral, 1 = angular

    // Working registers of the shared unit
    logic signed [VW-1:0]       r_cmd_fwd;
    logic signed [VW-1:0]       r_cmd_lat;
    logic signed [VW-1:0]       r_cmd_ang;
    logic [DW-1:0]              r_dt;
    logic [DEN_W-1:0]           r_den;
    logic [DEN_W-1:0]           r_rem;
    logic [QW-1:0]              r_num;
    logic [QW-1:0]              r_q;
    logic signed [OPA_W-1:0]    r_diff;
    logic signed [PROD_W-1:0]   r_prod;

    // Result register
    logic                       r_out_valid;
    logic [vcsl_pkg::OUT_TDATA_W-1:0] r_out_data;

    // ------------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------------
    logic w_in_fire;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------------
    // Per-axis selection for the lag sequence
    // ------------------------------------------------------------------------
    logic [LW-1:0]           w_tau;
    logic signed [VW-1:0]    w_tgt;
    logic signed [AW-1:0]    w_app;
    logic signed [AW-1:0]    w_goal;
    logic signed [OPA_W-1:0] w_diff;

    assign w_tau  = r_chan ? r_lag_ang : r_lag_lat;
    assign w_tgt  = r_chan ? r_tgt_ang : r_tgt_lat;
    assign w_app  = r_chan ? r_app_ang : r_app_lat;
    assign w_goal = {w_tgt, 8'h00};
    assign w_diff = OPA_W'(w_goal) - OPA_W'(w_app);

    // ------------------------------------------------------------------------
    // Shared multiplier. During scaling it takes a command and its gain; during
    // the lag step it takes the distance to the target and alpha.
    // ------------------------------------------------------------------------
    logic signed [VW-1:0]     w_cmd_sel;
    logic [GW-1:0]            w_gain_sel;
    logic signed [OPA_W-1:0]  w_mul_a;
    logic signed [OPB_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;

    always_comb begin
        case (r_cnt)
            CNT_W'(0): begin
                w_cmd_sel  = r_cmd_fwd;
                w_gain_sel = r_gain_fwd;
            end
            CNT_W'(1): begin
                w_cmd_sel  = r_cmd_lat;
                // Negative lateral commands use their own gain.
                w_gain_sel = r_cmd_lat[VW-1] ? r_gain_lat_neg : r_gain_lat_pos;
            end
            default: begin
                w_cmd_sel  = r_cmd_ang;
                w_gain_sel = r_gain_ang;
            end
        endcase
    end

    assign w_mul_a = (r_state == S_SCALE_MUL) ? OPA_W'(w_cmd_sel) : r_diff;
    assign w_mul_b = (r_state == S_SCALE_MUL) ? $signed(OPB_W'(w_gain_sel))
                                              : $signed(OPB_W'(r_q));
    assign w_prod  = w_mul_a * w_mul_b;

    // ------------------------------------------------------------------------
    // Post-multiply rounding and saturation
    // ------------------------------------------------------------------------
    logic signed [PROD_W-1:0] w_scl_sh;
    logic signed [VW-1:0]     w_scl;
    logic signed [PROD_W-1:0] w_lag_sh;
    logic signed [PROD_W-1:0] w_lag_sum;
    logic signed [AW-1:0]     w_lag;

    always_comb begin
        w_scl_sh = (r_prod + SCALE_HALF) >>> vcsl_pkg::SCALE_SHIFT;
        if (w_scl_sh > VEL_MAX_P) begin
            w_scl = 16'sh7FFF;
        end else if (w_scl_sh < VEL_MIN_P) begin
            w_scl = -16'sh8000;
        end else begin
            w_scl = w_scl_sh[VW-1:0];
        end

        w_lag_sh  = (r_prod + LAG_HALF) >>> F;
        w_lag_sum = w_lag_sh + PROD_W'(w_app);
        if (w_lag_sum > APP_MAX_P) begin
            w_lag = 24'sh7FFFFF;
        end else if (w_lag_sum < APP_MIN_P) begin
            w_lag = -24'sh800000;
        end else begin
            w_lag = w_lag_sum[AW-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Alpha divider, one quotient bit per cycle. The numerator is
    // dt * 2^F + den / 2; alpha never exceeds 2^F, so its bits above the
    // lowest F+1 are already smaller than den and seed the remainder.
    // ------------------------------------------------------------------------
    logic [NUM_W-1:0] w_num;
    logic [REM_W-1:0] w_trial;
    logic [REM_W-1:0] w_sub;
    logic             w_ge;

    assign w_num   = (NUM_W'(r_dt) << F) + NUM_W'(r_den >> 1);
    assign w_trial = {r_rem, r_num[QW-1]};
    assign w_sub   = w_trial - REM_W'(r_den);
    assign w_ge    = (w_trial >= REM_W'(r_den));

    // ------------------------------------------------------------------------
    // Control, configuration and architectural state
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_fwd     <= vcsl_pkg::GAIN_RESET;
            r_gain_lat_pos <= vcsl_pkg::GAIN_RESET;
            r_gain_lat_neg <= vcsl_pkg::GAIN_RESET;
            r_gain_ang     <= vcsl_pkg::GAIN_RESET;
            r_lag_lat      <= '0;
            r_lag_ang      <= '0;
            r_tgt_fwd      <= '0;
            r_tgt_lat      <= '0;
            r_tgt_ang      <= '0;
            r_app_lat      <= '0;
            r_app_ang      <= '0;
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_chan         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // The user must write configuration only while the core is idle; the core does not enforce it.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    vcsl_pkg::REG_FORWARD_GAIN:     r_gain_fwd     <= i_cfg_wdata[GW-1:0];
                    vcsl_pkg::REG_LATERAL_GAIN_POS: r_gain_lat_pos <= i_cfg_wdata[GW-1:0];
                    vcsl_pkg::REG_LATERAL_GAIN_NEG: r_gain_lat_neg <= i_cfg_wdata[GW-1:0];
                    vcsl_pkg::REG_ANGULAR_GAIN:     r_gain_ang     <= i_cfg_wdata[GW-1:0];
                    vcsl_pkg::REG_LATERAL_LAG:      r_lag_lat      <= i_cfg_wdata[LW-1:0];
                    vcsl_pkg::REG_ANGULAR_LAG:      r_lag_ang      <= i_cfg_wdata[LW-1:0];
                    default: begin
                    end
                endcase
            end

            // A taken result empties the output register; a new load below wins.
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_cnt  <= '0;
                        r_chan <= 1'b0;
                        if (s_axis_tuser == vcsl_pkg::ACTION_TICK) begin
                            r_state <= S_LAG_START;
                        end else begin
                            r_state <= S_SCALE_MUL;
                        end
                    end
                end

                S_SCALE_MUL: begin
                    r_state <= S_SCALE_WB;
                end

                S_SCALE_WB: begin
                    case (r_cnt)
                        CNT_W'(0): r_tgt_fwd <= w_scl;
                        CNT_W'(1): r_tgt_lat <= w_scl;
                        default:   r_tgt_ang <= w_scl;
                    endcase
                    if (r_cnt == SCALE_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_SCALE_MUL;
                    end
                end

                S_LAG_START: begin
                    if (w_tau == '0) begin
                        // No lag on this axis: jump straight to the target.
                        if (r_chan) begin
                            r_app_ang <= w_goal;
                            r_state   <= S_OUT;
                        end else begin
                            r_app_lat <= w_goal;
                            r_chan    <= 1'b1;
                        end
                    end else begin
                        r_state <= S_DIV_INIT;
                    end
                end

                S_DIV_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_LAG_MUL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end

                S_LAG_MUL: begin
                    r_state <= S_LAG_WB;
                end

                S_LAG_WB: begin
                    if (r_chan) begin
                        r_app_ang <= w_lag;
                        r_state   <= S_OUT;
                    end else begin
                        r_app_lat <= w_lag;
                        r_chan    <= 1'b1;
                        r_state   <= S_LAG_START;
                    end
                end

                S_OUT: begin
                    // Wait here only while an older result is still unclaimed.
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers, no reset needed
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd_fwd <= s_axis_tdata[15:0];
            r_cmd_lat <= s_axis_tdata[31:16];
            r_cmd_ang <= s_axis_tdata[47:32];
            r_dt      <= s_axis_tdata[67:48];
        end

        if (r_state == S_SCALE_MUL || r_state == S_LAG_MUL) begin
            r_prod <= w_prod;
        end

        if (r_state == S_LAG_START) begin
            r_den  <= DEN_W'(w_tau) + DEN_W'(r_dt);
            r_diff <= w_diff;
        end

        if (r_state == S_DIV_INIT) begin
            r_rem <= DEN_W'(w_num[NUM_W-1:QW]);
            r_num <= w_num[QW-1:0];
            r_q   <= '0;
        end

        if (r_state == S_DIV) begin
            r_rem <= w_ge ? w_sub[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_num <= r_num << 1;
            r_q   <= {r_q[QW-2:0], w_ge};
        end

        if (r_state == S_OUT && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {round_out(r_app_ang), round_out(r_app_lat), r_tgt_fwd};
        end
    end

endmodule

[sv/vcsl_checker.sv]
// ----------------------------------------------------------------------------
// Velocity command scale and lag - port checker
// Watches the stream ports of the core over time; bound to the core.
// ----------------------------------------------------------------------------
`include "velocity_command_scale_and_lag_core_macros.svh"

module vcsl_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [vcsl_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result keeps its value.
    `VCSL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output transaction changed while stalled")

    // An accepted transaction leaves the core busy in the cycle after it.
    `VCSL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input still ready right after an accepted transaction")

    // A command never produces a result.
    `VCSL_ASSERT_NEXT(a_command_silent, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == vcsl_pkg::ACTION_COMMAND), !$rose(m_axis_tvalid), "command transaction produced a result")

    // A result only appears at the end of a busy period.
    `VCSL_ASSERT_SAME(a_result_from_busy, i_clk, i_rst_n, $rose(m_axis_tvalid), !$past(s_axis_tready), "result appeared without the core being busy")

endmodule

bind velocity_command_scale_and_lag_core vcsl_checker u_vcsl_checker (.*);
